// ===== rtl/core/rts_pkg.sv =====
`timescale 1ns / 1ps

package rts_pkg;

    localparam int ID_W       = 6;
    localparam int ID_COUNT   = 1 << ID_W;
    localparam int HITS_W     = 32;
    localparam int SUM_W      = 64;
    localparam int OUT_TIME_W = 48;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_REPEAT  = 2'd2,
        ST_HALTED  = 2'd3
    } t_status;

endpackage

// ===== rtl/core/region_timing_statistics.sv =====
`timescale 1ns / 1ps

// Region timing statistics. Each event (region_id, begin/end, timestamp) is a
// transfer on the input channel; each one yields exactly one result transfer
// with a status and the region's statistics after the event. The block takes
// one event per cycle while the output is not stalled; each event is registered
// in stage 1 together with the region table read, and its update lands in the
// output register when stage 1 advances. That rate is set
// by the region table's read port and the forwarding register that covers
// back-to-back events on the same region. Valid marks live in flip-flops
// cleared by reset, so the table needs no clearing pass and the block is
// ready right out of reset.
// After the first sequence error (end on an unknown region, or a begin/end
// that does not alternate) the block halts: every later event reports halted
// and changes nothing until reset. Hit counts and totals saturate at all
// ones. Timestamps are taken in min(48, TIME_BITS) bits; periods wrap modulo
// 2^TIME_BITS.
module region_timing_statistics
    import rts_pkg::*;
#(
    parameter int REGIONS   = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ID_W-1:0]       i_region_id,
    input  logic                  i_is_end,
    input  logic [OUT_TIME_W-1:0] i_timestamp,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [ID_W-1:0]       o_region_echo,
    output logic                  o_region_open,
    output logic [HITS_W-1:0]     o_hit_count,
    output logic [OUT_TIME_W-1:0] o_last_period,
    output logic [SUM_W-1:0]      o_total_time,
    output logic [OUT_TIME_W-1:0] o_min_period,
    output logic [OUT_TIME_W-1:0] o_max_period
);

    localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    // stored timestamp width: the port carries 48 bits at most
    localparam int TS_W  = (TIME_BITS < OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

    typedef struct packed {
        logic                 open;
        logic [HITS_W-1:0]    hits;
        logic [TS_W-1:0]      start;
        logic [SUM_W-1:0]     sum;
        logic [TIME_BITS-1:0] shortest;
        logic [TIME_BITS-1:0] longest;
    } t_entry;

    localparam t_entry EMPTY_ENTRY = '{
        open:     1'b0,
        hits:     '0,
        start:    '0,
        sum:      '0,
        shortest: '1,
        longest:  '0
    };

    // region_id to table row, reduced modulo REGIONS at elaboration
    function automatic logic [ID_COUNT*IDX_W-1:0] build_map();
        logic [ID_COUNT*IDX_W-1:0] map;
        map = '0;
        for (int i = 0; i < ID_COUNT; i++) begin
            map[i*IDX_W +: IDX_W] = IDX_W'(i % REGIONS);
        end
        return map;
    endfunction

    localparam logic [ID_COUNT*IDX_W-1:0] REGION_MAP = build_map();

    // ---------------------------------------------------------------
    // Handshake: stage 1 advances into the output register when that
    // register is empty or being drained this cycle.
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_advance;
    logic in_xfer;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    logic [IDX_W-1:0] in_idx;
    assign in_idx = REGION_MAP[i_region_id*IDX_W +: IDX_W];

    // ---------------------------------------------------------------
    // Stage 1 registers: held event, registered table read, forward copy
    // ---------------------------------------------------------------
    logic [ID_W-1:0]  r_s1_id;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_end;
    logic [TS_W-1:0]  r_s1_ts;
    t_entry           r_rd;
    t_entry           r_fwd;
    logic             r_fwd_hit;

    t_entry           r_mem [REGIONS];
    logic [REGIONS-1:0] r_valid_bits;
    logic             r_halted;

    // stage 1 update results
    t_entry           cur;
    t_entry           upd;
    logic             cur_valid;
    logic             wr_en;
    logic             set_halt;
    t_status          status;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] per_out;
    logic [SUM_W:0]       sum_ext;

    always_comb begin
        // pick the entry the previous event just wrote when the read raced it
        cur_valid = r_valid_bits[r_s1_idx];
        cur       = r_fwd_hit ? r_fwd : r_rd;
        if (!cur_valid) begin
            cur = EMPTY_ENTRY;
        end

        period  = TIME_BITS'(r_s1_ts) - TIME_BITS'(cur.start);
        sum_ext = {1'b0, cur.sum} + (SUM_W + 1)'(period);

        upd      = cur;
        wr_en    = 1'b0;
        set_halt = 1'b0;
        per_out  = '0;
        status   = ST_OK;

        if (r_halted) begin
            status = ST_HALTED;
        end else if (!cur_valid) begin
            if (r_s1_end) begin
                status   = ST_UNKNOWN;
                set_halt = 1'b1;
            end else begin
                // open a fresh region
                upd       = EMPTY_ENTRY;
                upd.open  = 1'b1;
                upd.hits  = HITS_W'(1);
                upd.start = r_s1_ts;
                wr_en     = 1'b1;
            end
        end else if (cur.open == !r_s1_end) begin
            status   = ST_REPEAT;
            set_halt = 1'b1;
        end else if (!r_s1_end) begin
            if (cur.hits != '1) begin
                upd.hits = cur.hits + HITS_W'(1);
            end
            upd.start = r_s1_ts;
            upd.open  = 1'b1;
            wr_en     = 1'b1;
        end else begin
            // close the period: saturate the total, track min and max
            upd.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (period < cur.shortest) begin
                upd.shortest = period;
            end
            if (period > cur.longest) begin
                upd.longest = period;
            end
            upd.start = r_s1_ts;
            upd.open  = 1'b0;
            per_out   = period;
            wr_en     = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Region table: one write port from stage 1, one registered read
    // port at input transfer.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_advance && wr_en) begin
            r_mem[r_s1_idx] <= upd;
        end
        if (in_xfer) begin
            r_rd <= r_mem[in_idx];
        end
    end

    // stage 1 payload and forward copy
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_id   <= i_region_id;
            r_s1_idx  <= in_idx;
            r_s1_end  <= i_is_end;
            r_s1_ts   <= i_timestamp[TS_W-1:0];
            r_fwd     <= upd;
            r_fwd_hit <= s1_advance && wr_en && (r_s1_idx == in_idx);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_valid_bits <= '0;
            r_halted     <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_advance && wr_en) begin
                r_valid_bits[r_s1_idx] <= 1'b1;
            end
            if (s1_advance && set_halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: load on advance, hold while stalled
    // ---------------------------------------------------------------
    t_status               r_out_status;
    logic [ID_W-1:0]       r_out_echo;
    logic                  r_out_open;
    logic [HITS_W-1:0]     r_out_hits;
    logic [OUT_TIME_W-1:0] r_out_last;
    logic [SUM_W-1:0]      r_out_total;
    logic [OUT_TIME_W-1:0] r_out_min;
    logic [OUT_TIME_W-1:0] r_out_max;

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_status <= status;
            r_out_echo   <= r_s1_id;
            r_out_open   <= upd.open;
            r_out_hits   <= upd.hits;
            r_out_last   <= OUT_TIME_W'(per_out);
            r_out_total  <= upd.sum;
            r_out_min    <= OUT_TIME_W'(upd.shortest);
            r_out_max    <= OUT_TIME_W'(upd.longest);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_region_echo = r_out_echo;
    assign o_region_open = r_out_open;
    assign o_hit_count   = r_out_hits;
    assign o_last_period = r_out_last;
    assign o_total_time  = r_out_total;
    assign o_min_period  = r_out_min;
    assign o_max_period  = r_out_max;

endmodule

// ===== rtl/core/rts_checker.sv =====
`timescale 1ns / 1ps

module rts_checker
    import rts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [ID_W-1:0]       i_region_id,
    input logic                  i_is_end,
    input logic [OUT_TIME_W-1:0] i_timestamp,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [1:0]            o_status,
    input logic [ID_W-1:0]       o_region_echo,
    input logic                  o_region_open,
    input logic [HITS_W-1:0]     o_hit_count,
    input logic [OUT_TIME_W-1:0] o_last_period,
    input logic [SUM_W-1:0]      o_total_time,
    input logic [OUT_TIME_W-1:0] o_min_period,
    input logic [OUT_TIME_W-1:0] o_max_period
);

    logic out_xfer;
    logic r_seen_err;
    logic [1:0] r_pending;

    assign out_xfer = o_out_valid && i_out_ready;

    // remember that an error result has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
        end else if (out_xfer && (o_status != ST_OK)) begin
            r_seen_err <= 1'b1;
        end
    end

    // events taken but not yet delivered; two stages hold at most two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(i_in_valid && o_in_ready) - 2'(out_xfer);
        end
    end

    // hold the event while the block is not ready
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_region_id)
            && $stable(i_is_end) && $stable(i_timestamp))
        else $error("event changed while waiting");

    // hold the result while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_region_echo) && $stable(o_total_time)
            && $stable(o_hit_count) && $stable(o_region_open)
            && $stable(o_last_period) && $stable(o_min_period)
            && $stable(o_max_period))
        else $error("result changed while stalled");

    // halt is sticky: after an error every result reports halted
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen_err |-> o_status == ST_HALTED)
        else $error("result after an error is not halted");

    // an accepted event leaves a counted region; begins carry no period
    a_ok_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK) |->
            (o_hit_count != '0) && (!o_region_open || (o_last_period == '0)))
        else $error("accepted event with inconsistent statistics");

    // a result never appears without an event in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 2'd0)
        else $error("result without a pending event");

endmodule

bind region_timing_statistics rts_checker u_rts_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for region_timing_statistics.
// An initial block builds the whole event list up front. A falling-edge driver
// feeds it in bursts, and a rising-edge monitor predicts each accepted transfer
// and checks each result transfer against the oldest prediction.
module testbench;
    import rts_pkg::*;

    localparam int         NUM_REGIONS  = 64;
    localparam int         SAT_PAIRS    = 20;  // full-range periods on one region
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         NOISE_ITEMS  = 20;
    localparam int         MAX_REPORTS  = 40;
    localparam longint     CYCLE_LIMIT  = 200_000;
    localparam logic [47:0] TS_ONES     = '1;

    typedef struct {
        logic [ID_W-1:0]       region;
        logic                  is_end;
        logic [OUT_TIME_W-1:0] ts;
        logic                  wait_drain;  // hold this transfer until no result is pending
    } t_trace_event;

    typedef struct {
        t_status               status;
        logic [ID_W-1:0]       echo;
        logic                  open;
        logic [HITS_W-1:0]     hits;
        logic [OUT_TIME_W-1:0] last;
        logic [SUM_W-1:0]      total;
        logic [OUT_TIME_W-1:0] min_p;
        logic [OUT_TIME_W-1:0] max_p;
    } t_region_stats;

    // DUT ports; the inputs are at known values from time zero.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic [ID_W-1:0]       i_region_id   = '0;
    logic                  i_is_end      = 1'b0;
    logic [OUT_TIME_W-1:0] i_timestamp   = '0;
    logic                  i_out_ready   = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [1:0]            o_status;
    logic [ID_W-1:0]       o_region_echo;
    logic                  o_region_open;
    logic [HITS_W-1:0]     o_hit_count;
    logic [OUT_TIME_W-1:0] o_last_period;
    logic [SUM_W-1:0]      o_total_time;
    logic [OUT_TIME_W-1:0] o_min_period;
    logic [OUT_TIME_W-1:0] o_max_period;

    region_timing_statistics dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_region_id   (i_region_id),
        .i_is_end      (i_is_end),
        .i_timestamp   (i_timestamp),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_region_echo (o_region_echo),
        .o_region_open (o_region_open),
        .o_hit_count   (o_hit_count),
        .o_last_period (o_last_period),
        .o_total_time  (o_total_time),
        .o_min_period  (o_min_period),
        .o_max_period  (o_max_period)
    );

    always #10 i_clk = ~i_clk;

    t_trace_event  event_q[$];   // transfers not yet presented
    t_region_stats stats_q[$];   // predicted results not yet seen

    // Predictor copy of the region table.
    logic                  tab_valid [NUM_REGIONS];
    logic                  tab_open  [NUM_REGIONS];
    logic [HITS_W-1:0]     tab_hits  [NUM_REGIONS];
    logic [OUT_TIME_W-1:0] tab_start [NUM_REGIONS];
    logic [SUM_W-1:0]      tab_sum   [NUM_REGIONS];
    logic [OUT_TIME_W-1:0] tab_short [NUM_REGIONS];
    logic [OUT_TIME_W-1:0] tab_long  [NUM_REGIONS];
    logic                  tab_halted;

    // Generator shadow: just enough to keep sequences well formed.
    logic                  gen_valid [NUM_REGIONS];
    logic                  gen_open  [NUM_REGIONS];
    logic [OUT_TIME_W-1:0] gen_start [NUM_REGIONS];

    int     err_count    = 0;
    int     status_seen [4];
    int     closed_count = 0;
    bit     sum_saturated = 1'b0;
    longint cycle_count  = 0;
    logic   took         = 1'b0;  // input transfer happened at the last rising edge

    // Sender burst shaping and receiver stall pattern.
    int         burst_left = 1;
    int         gap_left   = 0;
    logic [7:0] ready_mask = 8'hFF;
    int         ready_tick = 0;

    initial begin
        for (int r = 0; r < NUM_REGIONS; r++) begin
            tab_valid[r] = 1'b0;
            tab_open[r]  = 1'b0;
            tab_hits[r]  = '0;
            tab_start[r] = '0;
            tab_sum[r]   = '0;
            tab_short[r] = '1;
            tab_long[r]  = '0;
            gen_valid[r] = 1'b0;
            gen_open[r]  = 1'b0;
            gen_start[r] = '0;
        end
        tab_halted = 1'b0;
        for (int s = 0; s < 4; s++) status_seen[s] = 0;
    end

    // Advance the predicted table by one event and return the expected result.
    function automatic t_region_stats apply_event(input logic [ID_W-1:0] id,
                                                  input logic is_end,
                                                  input logic [OUT_TIME_W-1:0] ts);
        t_region_stats   res;
        int              r;
        logic [47:0]     period;
        logic [SUM_W:0]  wide;
        r          = int'(id) % NUM_REGIONS;
        period     = '0;
        res.status = ST_OK;
        if (tab_halted) begin
            res.status = ST_HALTED;
        end else if (!tab_valid[r]) begin
            if (is_end) begin
                tab_halted = 1'b1;
                res.status = ST_UNKNOWN;
            end else begin
                tab_valid[r] = 1'b1;
                tab_open[r]  = 1'b1;
                tab_hits[r]  = HITS_W'(1);
                tab_start[r] = ts;
                tab_sum[r]   = '0;
                tab_short[r] = '1;
                tab_long[r]  = '0;
            end
        end else if (tab_open[r] == !is_end) begin
            // begin on an open region, or end on a closed one
            tab_halted = 1'b1;
            res.status = ST_REPEAT;
        end else if (!is_end) begin
            if (tab_hits[r] != '1) tab_hits[r] = tab_hits[r] + HITS_W'(1);
            tab_start[r] = ts;
            tab_open[r]  = 1'b1;
        end else begin
            period = ts - tab_start[r];  // wraps with the free-running timer
            wide   = {1'b0, tab_sum[r]} + {17'd0, period};
            if (wide[SUM_W]) begin
                tab_sum[r]    = '1;
                sum_saturated = 1'b1;
            end else begin
                tab_sum[r] = wide[SUM_W-1:0];
            end
            if (period < tab_short[r]) tab_short[r] = period;
            if (period > tab_long[r])  tab_long[r]  = period;
            tab_start[r] = ts;
            tab_open[r]  = 1'b0;
            closed_count++;
        end
        status_seen[res.status]++;
        res.echo  = id;
        res.open  = tab_open[r];
        res.hits  = tab_hits[r];
        res.last  = period;
        res.total = tab_sum[r];
        res.min_p = tab_short[r];
        res.max_p = tab_long[r];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Queue one event and keep the generator shadow in step with it.
    task automatic push_event(input logic [ID_W-1:0] id, input logic is_end,
                              input logic [OUT_TIME_W-1:0] ts, input logic drain);
        t_trace_event ev;
        ev.region     = id;
        ev.is_end     = is_end;
        ev.ts         = ts;
        ev.wait_drain = drain;
        event_q.push_back(ev);
        if (!is_end) begin
            gen_valid[id] = 1'b1;
            gen_open[id]  = 1'b1;
        end else begin
            gen_open[id]  = 1'b0;
        end
        gen_start[id] = ts;
    endtask

    function automatic logic [OUT_TIME_W-1:0] rand_ts();
        return OUT_TIME_W'({$urandom, $urandom});
    endfunction

    // Queue the next legal event for a region: end if open, else begin.
    task automatic push_legal(input logic [ID_W-1:0] id, input logic drain);
        logic [OUT_TIME_W-1:0] ts;
        logic [OUT_TIME_W-1:0] base;
        base = gen_start[id];
        if (gen_valid[id] && gen_open[id]) begin
            case ($urandom_range(0, 5))
                0:       ts = rand_ts();                      // anything, often wrapping
                1:       ts = base + $urandom_range(0, 1000);
                2:       ts = base;                           // zero-length period
                3:       ts = base - 1;                       // longest possible period
                4:       ts = base + $urandom;
                default: ts = base + $urandom_range(1, 64);
            endcase
            push_event(id, 1'b1, ts, drain);
        end else begin
            case ($urandom_range(0, 5))
                0:       ts = '0;
                1:       ts = TS_ONES;
                2, 3:    ts = base + $urandom_range(0, 5000);
                default: ts = rand_ts();
            endcase
            push_event(id, 1'b0, ts, drain);
        end
    endtask

    // Monitor: check the result side first, then predict the input side.
    always @(posedge i_clk) begin : monitor
        t_region_stats want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
        took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (stats_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: result with none expected, region %0h status %0h",
                                 $time, o_region_echo, o_status);
                end else begin
                    want = stats_q.pop_front();
                    check_field("status",      64'(want.status), 64'(o_status));
                    check_field("region_echo", 64'(want.echo),   64'(o_region_echo));
                    check_field("region_open", 64'(want.open),   64'(o_region_open));
                    check_field("hit_count",   64'(want.hits),   64'(o_hit_count));
                    check_field("last_period", 64'(want.last),   64'(o_last_period));
                    check_field("total_time",  want.total,       o_total_time);
                    check_field("min_period",  64'(want.min_p),  64'(o_min_period));
                    check_field("max_period",  64'(want.max_p),  64'(o_max_period));
                end
            end
            if (i_in_valid && o_in_ready)
                stats_q.push_back(apply_event(i_region_id, i_is_end, i_timestamp));
        end
    end

    // Driver: change inputs on the falling edge only.
    always @(negedge i_clk) begin : driver
        t_trace_event ev;
        if (i_rst_n) begin
            // Receiver: rotate a stall mask; each redraw is either all ready or random with bit 0 set.
            ready_tick++;
            if (ready_tick % 64 == 0) begin
                if ($urandom_range(0, 3) == 0) ready_mask = 8'hFF;
                else                           ready_mask = 8'($urandom | $urandom) | 8'h01;
            end
            i_out_ready <= ready_mask[ready_tick % 8];

            // Sender: hold an unaccepted transfer, else advance to the next one.
            if (!i_in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (event_q.size() == 0 ||
                             (event_q[0].wait_drain && stats_q.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    ev = event_q.pop_front();
                    i_region_id <= ev.region;
                    i_is_end    <= ev.is_end;
                    i_timestamp <= ev.ts;
                    i_in_valid  <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int                    reserved;
        int                    sat_region;
        int                    err_kind;
        int                    r;
        int                    prev;
        logic [OUT_TIME_W-1:0] t0;

        // Pick the one sequence error this run ends with. An end on an unknown
        // region needs a region that traffic never touches: reserve one.
        err_kind = $urandom_range(0, 2);
        reserved = -1;
        if (err_kind == 0) begin
            do reserved = $urandom_range(2, 62); while (reserved == 21 || reserved == 42);
        end
        sat_region = (reserved == 5) ? 6 : 5;

        // Directed: timestamp extremes, zero and full-range periods, wrap,
        // min/max updates, interleaved regions, all region-index bits.
        push_event(6'd0,  1'b0, '0, 1'b0);
        push_event(6'd0,  1'b1, '0, 1'b0);
        push_event(6'd63, 1'b0, TS_ONES, 1'b0);
        push_event(6'd63, 1'b1, TS_ONES - 1, 1'b0);
        push_event(6'd42, 1'b0, 48'd1000, 1'b0);
        push_event(6'd21, 1'b0, 48'd5, 1'b0);
        push_event(6'd42, 1'b1, 48'd1300, 1'b0);
        push_event(6'd21, 1'b1, 48'h8000_0000_0000, 1'b0);
        push_event(6'd42, 1'b0, 48'd2000, 1'b0);
        push_event(6'd42, 1'b1, 48'd2010, 1'b0);
        push_event(6'd42, 1'b0, 48'd3000, 1'b0);
        push_event(6'd42, 1'b1, 48'd4000, 1'b0);
        push_event(6'd1,  1'b0, 48'd100, 1'b0);
        push_event(6'd1,  1'b1, 48'd50, 1'b0);
        push_event(6'd0,  1'b0, 48'd7, 1'b0);
        push_event(6'd0,  1'b1, 48'h8000_0000_0007, 1'b0);
        push_event(6'd63, 1'b0, 48'h5555_5555_5555, 1'b0);
        push_event(6'd63, 1'b1, 48'hAAAA_AAAA_AAAA, 1'b0);

        // Random well-formed traffic; the first transfer waits for a drain.
        prev = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 4) begin
                r = prev;  // back-to-back on one region hits the forwarding path
            end else begin
                do r = $urandom_range(0, NUM_REGIONS - 1); while (r == reserved);
            end
            push_legal(r[ID_W-1:0], n == 0);
            prev = r;
        end

        // Large totals: repeat full-range periods on one region.
        if (gen_open[sat_region]) push_legal(sat_region[ID_W-1:0], 1'b1);
        for (int n = 0; n < SAT_PAIRS; n++) begin
            t0 = rand_ts();
            push_event(sat_region[ID_W-1:0], 1'b0, t0, n == 0);
            push_event(sat_region[ID_W-1:0], 1'b1, t0 - 1, 1'b0);
        end

        // One sequence error halts the block for good, so it comes last.
        do r = $urandom_range(0, NUM_REGIONS - 1); while (r == reserved);
        case (err_kind)
            0: push_event(reserved[ID_W-1:0], 1'b1, rand_ts(), 1'b1);
            1: begin
                if (!gen_open[r]) push_legal(r[ID_W-1:0], 1'b1);
                push_event(r[ID_W-1:0], 1'b0, rand_ts(), 1'b0);
            end
            default: begin
                while (!gen_valid[r] || gen_open[r]) push_legal(r[ID_W-1:0], 1'b1);
                push_event(r[ID_W-1:0], 1'b1, rand_ts(), 1'b0);
            end
        endcase
        // Noise after the halt: everything must report halted.
        for (int n = 0; n < NOISE_ITEMS; n++)
            push_event(ID_W'($urandom_range(0, NUM_REGIONS - 1)), 1'($urandom_range(0, 1)),
                       rand_ts(), 1'b0);

        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all transfers taken, then all results seen, then settle.
        while (event_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (stats_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d periods closed; statuses ok/unknown/repeat/halted = %0d/%0d/%0d/%0d",
                 closed_count, status_seen[ST_OK], status_seen[ST_UNKNOWN],
                 status_seen[ST_REPEAT], status_seen[ST_HALTED]);
        $display("total-time saturation reached: %0s, %0d mismatches, %0d cycles",
                 sum_saturated ? "yes" : "no", err_count, cycle_count);
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
